### hw/rtl/aposc_pkg.sv
// ----------------------------------------------------------------------------
// aposc_pkg
// Shared types, constants and the damping weight table of the oscillator bank.
// ----------------------------------------------------------------------------
package aposc_pkg;

    localparam int PARTIALS    = 32;
    localparam int TABLE_BITS  = 12;
    localparam int WAVE_TABLES = 4;
    localparam int RATIO_SETS  = 8;

    localparam int KW    = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int RAD_W = $clog2(RATIO_SETS * PARTIALS);
    localparam int WAD_W = $clog2(WAVE_TABLES << TABLE_BITS);
    localparam int WS_W  = 2;
    localparam int RS_W  = 3;
    localparam int CFG_W = 3;
    localparam int EXP_DEPTH = 1024;

    localparam logic [31:0] MAX_STEP = 32'd341782637;

    // configuration register indexes
    localparam logic CFG_WAVE_SEL  = 1'b0;
    localparam logic CFG_RATIO_SEL = 1'b1;

    // command kinds
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_AMP   = 3'd1;
    localparam logic [2:0] CMD_RATIO = 3'd2;
    localparam logic [2:0] CMD_WAVE  = 3'd3;
    localparam logic [2:0] CMD_NOP   = 3'd4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KW-1:0]    pidx;
        logic [RAD_W-1:0] raddr;
        logic [WAD_W-1:0] waddr;
        logic [23:0]      value;
        logic [31:0]      base;
        logic [9:0]       damp;
    } t_cmd;

    typedef struct packed {
        logic [WS_W-1:0] ws;
        logic [RS_W-1:0] rs;
    } t_cfg;

    typedef logic [15:0] t_exp_rom [EXP_DEPTH];

    // exp(-e*10/1023) in Q0.16: series in Q30, then squared four times
    function automatic logic [15:0] exp_weight(int unsigned e);
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] u;
        longint      s;
        int          n;
        y = ((64'(e) * 64'd10) << 30) / 64'd16368;
        t = 64'd1 << 30;
        s = longint'(t);
        for (n = 1; n <= 12; n++) begin
            t = ((t * y) >> 30) / 64'(n);
            if (n % 2 == 1) s = s - longint'(t);
            else s = s + longint'(t);
        end
        u = (s < 0) ? 64'd0 : 64'(s);
        for (n = 0; n < 4; n++) begin
            u = (u * u) >> 30;
        end
        u = (u + 64'd8192) >> 14;
        return (u > 64'hFFFF) ? 16'hFFFF : u[15:0];
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom r;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            r[i] = exp_weight(i);
        end
        return r;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

### hw/rtl/additive_partial_oscillator_bank.sv
// ----------------------------------------------------------------------------
// additive_partial_oscillator_bank
// Additive oscillator bank: per-partial phase update and weighted wavetable sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (i_valid / o_stall) carry a mode: a sample tick, or a write
//   of an amplitude, a ratio entry or a wavetable word. A request is taken at
//   a clock edge with i_valid high and o_stall low; it enters a two-entry
//   command queue, so the front keeps taking requests while the engine works.
//   Writes give no result. A tick gives one o_sample
//   on the result channel (o_valid / i_stall).
//   A tick walks the partials through a five-stage pipeline, one partial per
//   cycle, using the single read port of the ratio and wavetable memories;
//   o_valid rises once the last partial has left the pipeline and the sum
//   is rounded into the output register. A new tick leaves the queue only
//   after the previous result has left the output register.
//   Results wait in an output register; while the receiver stalls, the next
//   tick waits at the queue head, writes ahead of it still go through, and
//   o_stall rises once the queue holds two requests.
//   Configuration (wave and ratio selects) is written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while the block is idle.
//   Synchronous reset clears phases, amplitudes, selects and control; ratio
//   and wavetable memories hold no defined value until written.
// ----------------------------------------------------------------------------
module additive_partial_oscillator_bank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [2:0]          i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [4:0]          i_partial_index,
    input  logic [2:0]          i_set_index,
    input  logic [11:0]         i_table_address,
    input  logic signed [24:0]  i_write_value,
    input  logic [31:0]         i_base_increment,
    input  logic [9:0]          i_damping_setting,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_sample
);
    import aposc_pkg::*;

    logic [WS_W-1:0] r_wave_sel;
    logic [RS_W-1:0] r_ratio_sel;
    t_cfg            cfg;
    t_cmd            dec_cmd;
    t_cmd            head;
    logic            q_full;
    logic            q_nempty;
    logic            pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel  <= '0;
            r_ratio_sel <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVE_SEL:  r_wave_sel  <= i_cfg_data[WS_W-1:0];
                CFG_RATIO_SEL: r_ratio_sel <= i_cfg_data[RS_W-1:0];
                default: ;
            endcase
        end
    end

    // selects saturate to the last table or set
    assign cfg.ws = (int'(r_wave_sel) < WAVE_TABLES) ? r_wave_sel
                    : WS_W'(WAVE_TABLES - 1);
    assign cfg.rs = (int'(r_ratio_sel) < RATIO_SETS) ? r_ratio_sel
                    : RS_W'(RATIO_SETS - 1);

    assign o_stall = q_full;

    aposc_front u_front (
        .i_mode            (i_mode),
        .i_partial_index   (i_partial_index),
        .i_set_index       (i_set_index),
        .i_table_address   (i_table_address),
        .i_write_value     (i_write_value),
        .i_base_increment  (i_base_increment),
        .i_damping_setting (i_damping_setting),
        .o_cmd             (dec_cmd)
    );

    aposc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_valid && !q_full),
        .i_data   (dec_cmd),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_head   (head)
    );

    aposc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cmd_v  (q_nempty),
        .i_cmd    (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_sample (o_sample)
    );

endmodule

### hw/rtl/aposc_front.sv
// ----------------------------------------------------------------------------
// aposc_front
// Decodes an input request into a command: range checks and value clamping.
// ----------------------------------------------------------------------------
module aposc_front (
    input  logic [1:0]            i_mode,
    input  logic [4:0]            i_partial_index,
    input  logic [2:0]            i_set_index,
    input  logic [11:0]           i_table_address,
    input  logic signed [24:0]    i_write_value,
    input  logic [31:0]           i_base_increment,
    input  logic [9:0]            i_damping_setting,
    output aposc_pkg::t_cmd       o_cmd
);
    import aposc_pkg::*;

    logic        pidx_ok;
    logic        rset_ok;
    logic        wset_ok;
    logic [15:0] amp_c;
    logic [23:0] rat_c;
    logic [17:0] wav_c;

    assign pidx_ok = int'(i_partial_index) < PARTIALS;
    assign rset_ok = int'(i_set_index) < RATIO_SETS;
    assign wset_ok = int'(i_set_index) < WAVE_TABLES;

    // saturate write values to their store widths
    always_comb begin
        if (i_write_value > 25'sd32767) amp_c = 16'h7FFF;
        else if (i_write_value < -25'sd32768) amp_c = 16'h8000;
        else amp_c = i_write_value[15:0];

        if (i_write_value[24]) rat_c = 24'd0;
        else rat_c = i_write_value[23:0];

        if (i_write_value > 25'sd131071) wav_c = 18'h1FFFF;
        else if (i_write_value < -25'sd131072) wav_c = 18'h20000;
        else wav_c = i_write_value[17:0];
    end

    // classify
    always_comb begin
        o_cmd.pidx  = i_partial_index[KW-1:0];
        o_cmd.raddr = RAD_W'(int'(i_set_index) * PARTIALS + int'(i_partial_index));
        o_cmd.waddr = WAD_W'((int'(i_set_index) << TABLE_BITS)
                      | int'(i_table_address[TABLE_BITS-1:0]));
        o_cmd.base  = i_base_increment;
        o_cmd.damp  = i_damping_setting;
        o_cmd.value = 24'd0;
        case (i_mode)
            2'd0: begin
                o_cmd.kind = CMD_TICK;
            end
            2'd1: begin
                o_cmd.kind  = pidx_ok ? CMD_AMP : CMD_NOP;
                o_cmd.value = {8'd0, amp_c};
            end
            2'd2: begin
                o_cmd.kind  = (pidx_ok && rset_ok) ? CMD_RATIO : CMD_NOP;
                o_cmd.value = rat_c;
            end
            2'd3: begin
                o_cmd.kind  = wset_ok ? CMD_WAVE : CMD_NOP;
                o_cmd.value = {6'd0, wav_c};
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

### hw/rtl/aposc_queue.sv
// ----------------------------------------------------------------------------
// aposc_queue
// Two-entry command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module aposc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aposc_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output aposc_pkg::t_cmd o_head
);
    import aposc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_head   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### hw/rtl/aposc_back.sv
// ----------------------------------------------------------------------------
// aposc_back
// Executes commands: store writes, and the pipelined pass over all partials.
// ----------------------------------------------------------------------------
module aposc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aposc_pkg::t_cfg      i_cfg,
    input  logic                 i_cmd_v,
    input  aposc_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_sample
);
    import aposc_pkg::*;

    // stores
    logic [23:0] r_ratio [RATIO_SETS*PARTIALS];
    logic [17:0] r_wave  [WAVE_TABLES<<TABLE_BITS];
    logic [31:0] r_phase [PARTIALS];
    logic [15:0] r_amp   [PARTIALS];

    // control
    logic            r_busy;
    logic            r_iss;
    logic [KW-1:0]   r_k;
    logic [31:0]     r_base;
    logic [9:0]      r_dinv;
    t_cfg            r_cfg;
    logic            take;
    logic            w_amp;
    logic            w_rat;
    logic            w_wav;

    // pipeline
    logic            r_b_v, r_b_l;
    logic [KW-1:0]   r_b_k;
    logic [23:0]     r_b_rat;
    logic [31:0]     r_b_ph;
    logic [15:0]     r_b_amp;
    logic [15:0]     r_b_w;
    logic            r_c_v, r_c_l;
    logic [KW-1:0]   r_c_k;
    logic [55:0]     r_c_prod;
    logic [31:0]     r_c_ph;
    logic signed [32:0] r_c_aw;
    logic            r_d_v, r_d_l;
    logic signed [17:0] r_d_wav;
    logic signed [32:0] r_d_aw;
    logic            r_e_v, r_e_l;
    logic signed [50:0] r_e_term;
    logic signed [55:0] r_acc;
    logic            r_fin;
    logic            r_out_v;
    logic signed [31:0] r_out;

    logic [10+KW-1:0] e_prod;
    logic [10+KW-1:0] e_sh;
    logic [9:0]       e_idx;
    logic [39:0]      stp_w;
    logic [31:0]      stp;
    logic [31:0]      nph;
    logic [WAD_W-1:0] wrd_addr;
    logic [RAD_W-1:0] rrd_addr;
    logic signed [55:0] rnd;
    logic signed [37:0] shv;
    logic signed [31:0] sat;

    assign take  = i_cmd_v && !r_busy && (i_cmd.kind != CMD_TICK || !r_out_v);
    assign o_pop = take;
    assign w_amp = take && i_cmd.kind == CMD_AMP;
    assign w_rat = take && i_cmd.kind == CMD_RATIO;
    assign w_wav = take && i_cmd.kind == CMD_WAVE;

    // damping exponent, phase step, next phase and read addresses
    always_comb begin
        e_prod   = (10+KW)'(r_dinv) * (10+KW)'(r_k);
        e_sh     = e_prod >> 5;
        e_idx    = (e_sh > (10+KW)'(1023)) ? 10'd1023 : e_sh[9:0];
        rrd_addr = RAD_W'(int'(r_cfg.rs) * PARTIALS + int'(r_k));
        stp_w    = r_c_prod[55:16];
        stp      = (stp_w > 40'(MAX_STEP)) ? MAX_STEP : stp_w[31:0];
        nph      = r_c_ph + stp;
        wrd_addr = WAD_W'((int'(r_cfg.ws) << TABLE_BITS)
                   | int'(nph[31 -: TABLE_BITS]));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_rat) r_ratio[i_cmd.raddr] <= i_cmd.value;
        r_b_rat <= r_ratio[rrd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wav) r_wave[i_cmd.waddr] <= i_cmd.value[17:0];
        r_d_wav <= $signed(r_wave[wrd_addr]);
    end

    // phase and amplitude registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PARTIALS; i++) begin
                r_phase[i] <= 32'd0;
                r_amp[i]   <= 16'd0;
            end
        end else begin
            if (r_c_v) r_phase[r_c_k] <= nph;
            if (w_amp) r_amp[i_cmd.pidx] <= i_cmd.value[15:0];
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_b_k    <= r_k;
        r_b_ph   <= r_phase[r_k];
        r_b_amp  <= r_amp[r_k];
        r_b_w    <= EXP_ROM[e_idx];
        r_c_k    <= r_b_k;
        r_c_prod <= 56'(r_base) * 56'(r_b_rat);
        r_c_ph   <= r_b_ph;
        r_c_aw   <= $signed(r_b_amp) * $signed({1'b0, r_b_w});
        r_d_aw   <= r_c_aw;
        r_e_term <= r_d_aw * r_d_wav;
    end

    // rounding and saturation of the sum
    always_comb begin
        rnd = r_acc + 56'sd131072;
        shv = 38'(rnd >>> 18);
        if (shv > 38'sd2147483647) sat = 32'sh7FFFFFFF;
        else if (shv < -38'sd2147483648) sat = 32'sh80000000;
        else sat = shv[31:0];
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_iss   <= 1'b0;
            r_k     <= '0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_fin   <= 1'b0;
            r_out_v <= 1'b0;
            r_b_l   <= 1'b0;
            r_c_l   <= 1'b0;
            r_d_l   <= 1'b0;
            r_e_l   <= 1'b0;
            r_acc   <= '0;
        end else begin
            if (take && i_cmd.kind == CMD_TICK) begin
                r_busy <= 1'b1;
                r_iss  <= 1'b1;
                r_k    <= '0;
                r_base <= i_cmd.base;
                r_dinv <= 10'd1023 - i_cmd.damp;
                r_cfg  <= i_cfg;
                r_acc  <= '0;
            end else begin
                if (r_iss) begin
                    r_k <= r_k + KW'(1);
                    if (int'(r_k) == PARTIALS - 1) r_iss <= 1'b0;
                end
                if (r_e_v) r_acc <= r_acc + 56'(r_e_term);
            end
            r_b_v <= r_iss;
            r_b_l <= r_iss && int'(r_k) == PARTIALS - 1;
            r_c_v <= r_b_v;
            r_c_l <= r_b_l;
            r_d_v <= r_c_v;
            r_d_l <= r_c_l;
            r_e_v <= r_d_v;
            r_e_l <= r_d_l;
            r_fin <= r_e_v && r_e_l;
            if (r_fin) begin
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
                r_out   <= sat;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_sample = r_out;

    // checks
    a_fin_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !r_out_v) else $error("result finished while output slot full");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !take) else $error("command taken during a tick pass");
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss |-> r_busy) else $error("partial issued outside a tick pass");
    a_fin_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> !r_busy) else $error("tick pass did not end after its sum");

endmodule
